// ----- rtl/core/tile_index_to_block_coords_defines.svh -----
// assertion macros used by the tile mapping rtl
`ifndef TILE_INDEX_TO_BLOCK_COORDS_DEFINES_SVH
`define TILE_INDEX_TO_BLOCK_COORDS_DEFINES_SVH

// same-cycle implication, off during reset
`define TIBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TIBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tibc_pkg.sv -----
// types, register codes and bit helpers for the tile index mapper
package tibc_pkg;

    localparam int FIELD_W    = 16;
    localparam int END_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SIDES      = 2;
    localparam int SIDE_ROW   = 0;
    localparam int SIDE_COL   = 1;

    localparam logic [FIELD_W-1:0] START_MAX = 16'hffff;
    localparam logic [END_W-1:0]   END_MAX   = 17'h10000;

    typedef enum logic [1:0] {
        ORDER_LINEAR = 2'd0,
        ORDER_Z      = 2'd1,
        ORDER_U      = 2'd2
    } t_order;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER     = 3'd0,
        CFG_BASE_LOG2 = 3'd1,
        CFG_RROW_LOG2 = 3'd2,
        CFG_RCOL_LOG2 = 3'd3,
        CFG_SMALL_ROW = 3'd4,
        CFG_SMALL_COL = 3'd5,
        CFG_LARGE_ROW = 3'd6,
        CFG_LARGE_COL = 3'd7
    } t_cfg_reg;

    // even bits of a z-order code
    function automatic logic [7:0] pick_even(input logic [FIELD_W-1:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[2*i];
        end
        return r;
    endfunction

    // odd bits of a z-order code
    function automatic logic [7:0] pick_odd(input logic [FIELD_W-1:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[2*i+1];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/tile_index_to_block_coords.sv -----
// tile index to block position and row/column span, four-stage pipeline
//
//  channel   | dir | handshake             | word
//  ----------+-----+-----------------------+-------------------------------------
//  tile in   | in  | i_valid / o_stall     | i_tile_index
//  block out | out | o_valid / i_stall     | block_row/col, row/col start and end
//  config    | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one word per cycle while i_stall is low; stages in order: curve decode,
//  block add, span multiply, span sum and saturate, each a register stage
//  reset clears the stage valids and every config register to zero
//  each stage advances when the one after it is empty or moving, so bubbles
//  close up; o_stall rises only when all four stages hold a word
//  config is always ready; user must write it only while pipe is empty, unchecked
`include "tile_index_to_block_coords_defines.svh"

module tile_index_to_block_coords #(
    parameter int INDEX_BITS = 16,
    parameter int ROW_KERNEL = 8,
    parameter int COL_KERNEL = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [tibc_pkg::FIELD_W-1:0]   i_tile_index,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tibc_pkg::FIELD_W-1:0]   o_block_row,
    output logic [tibc_pkg::FIELD_W-1:0]   o_block_col,
    output logic [tibc_pkg::FIELD_W-1:0]   o_row_start,
    output logic [tibc_pkg::END_W-1:0]     o_row_end,
    output logic [tibc_pkg::FIELD_W-1:0]   o_col_start,
    output logic [tibc_pkg::END_W-1:0]     o_col_end,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tibc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tibc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tibc_pkg::*;

    localparam int IdxW    = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
    localparam logic [FIELD_W-1:0] IdxMask = FIELD_W'((33'd1 << IdxW) - 33'd1);
    localparam int KernMax = (ROW_KERNEL > COL_KERNEL) ? ROW_KERNEL : COL_KERNEL;
    localparam int KernW   = $clog2(KernMax + 1);
    localparam int ProdW   = 2 * FIELD_W;
    localparam int KprodW  = FIELD_W + KernW;
    localparam int SumW    = ((KprodW > ProdW) ? KprodW : ProdW) + 1;
    localparam int EndSumW = SumW + 1;
    localparam logic [KernW-1:0] Kern [SIDES] = '{KernW'(ROW_KERNEL), KernW'(COL_KERNEL)};

    // config registers
    t_order             r_order;
    logic [3:0]         r_base;
    logic [4:0]         r_rect  [SIDES];
    logic [FIELD_W-1:0] r_small [SIDES];
    logic [FIELD_W-1:0] r_large [SIDES];

    // stage valids and enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // stage 1: local curve position and masked repeat count per side
    logic [FIELD_W-1:0] r_lpos [SIDES];
    logic [FIELD_W-1:0] r_rep  [SIDES];
    // stage 2: block position and large-block test
    logic [FIELD_W-1:0] r_blk2 [SIDES];
    logic [FIELD_W-1:0] r_lo   [SIDES];
    logic               r_lt   [SIDES];
    // stage 3: products and end increment
    logic [FIELD_W-1:0] r_blk3  [SIDES];
    logic [ProdW-1:0]   r_prod  [SIDES];
    logic [KprodW-1:0]  r_kprod [SIDES];
    logic [END_W-1:0]   r_tail  [SIDES];
    // stage 4: output word
    logic [FIELD_W-1:0] r_blk4  [SIDES];
    logic [FIELD_W-1:0] r_start [SIDES];
    logic [END_W-1:0]   r_end   [SIDES];

    // stage 1 combinational
    logic [FIELD_W-1:0] idx;
    logic [4:0]         sh2;
    logic [31:0]        m2;
    logic [FIELD_W-1:0] n1;
    logic [FIELD_W-1:0] mb;
    logic [7:0]         ev;
    logic [7:0]         od;
    logic [FIELD_W-1:0] ri;
    logic [32:0]        rmask   [SIDES];
    logic [FIELD_W-1:0] n_lpos  [SIDES];
    logic [FIELD_W-1:0] n_rep   [SIDES];
    // later stages combinational
    logic [FIELD_W-1:0] shl     [SIDES];
    logic [FIELD_W-1:0] n_blk2  [SIDES];
    logic [SumW-1:0]    sum_s   [SIDES];
    logic [EndSumW-1:0] sum_e   [SIDES];
    logic [FIELD_W-1:0] n_start [SIDES];
    logic [END_W-1:0]   n_end   [SIDES];

    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_comb begin
        idx = i_tile_index & IdxMask;
        sh2 = {r_base, 1'b0};
        m2  = (32'd1 << sh2) - 32'd1;
        n1  = idx & m2[FIELD_W-1:0];
        mb  = FIELD_W'((17'd1 << r_base) - 17'd1);
        ev  = pick_even(n1);
        od  = pick_odd(n1);
        ri  = idx >> sh2;
        if (r_order == ORDER_LINEAR) begin
            n_lpos[SIDE_ROW] = n1 & mb;
            n_lpos[SIDE_COL] = n1 >> r_base;
        end else begin
            // u-order folds the column into the row
            n_lpos[SIDE_ROW] = {8'd0, (r_order == ORDER_U) ? (ev ^ od) : ev};
            n_lpos[SIDE_COL] = {8'd0, od};
        end
        for (int s = 0; s < SIDES; s++) begin
            rmask[s] = (33'd1 << r_rect[s]) - 33'd1;
            n_rep[s] = ri & rmask[s][FIELD_W-1:0];
        end
    end

    always_comb begin
        for (int s = 0; s < SIDES; s++) begin
            shl[s]    = r_rep[s] << r_base;
            n_blk2[s] = r_lpos[s] + shl[s];
            sum_s[s]  = SumW'(r_prod[s]) + SumW'(r_kprod[s]);
            sum_e[s]  = EndSumW'(sum_s[s]) + EndSumW'(r_tail[s]);
            n_start[s] = (sum_s[s] > SumW'(START_MAX)) ? START_MAX : sum_s[s][FIELD_W-1:0];
            n_end[s]   = (sum_e[s] > EndSumW'(END_MAX)) ? END_MAX : sum_e[s][END_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_LINEAR;
            r_base  <= '0;
            for (int s = 0; s < SIDES; s++) begin
                r_rect[s]  <= '0;
                r_small[s] <= '0;
                r_large[s] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ORDER:     r_order           <= t_order'(i_cfg_data[1:0]);
                CFG_BASE_LOG2: r_base            <= i_cfg_data[3:0];
                CFG_RROW_LOG2: r_rect[SIDE_ROW]  <= i_cfg_data[4:0];
                CFG_RCOL_LOG2: r_rect[SIDE_COL]  <= i_cfg_data[4:0];
                CFG_SMALL_ROW: r_small[SIDE_ROW] <= i_cfg_data;
                CFG_SMALL_COL: r_small[SIDE_COL] <= i_cfg_data;
                CFG_LARGE_ROW: r_large[SIDE_ROW] <= i_cfg_data;
                CFG_LARGE_COL: r_large[SIDE_COL] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SIDES; s++) begin
            if (en1) begin
                r_lpos[s] <= n_lpos[s];
                r_rep[s]  <= n_rep[s];
            end
            if (en2) begin
                r_blk2[s] <= n_blk2[s];
                r_lt[s]   <= n_blk2[s] < r_large[s];
                r_lo[s]   <= (n_blk2[s] < r_large[s]) ? n_blk2[s] : r_large[s];
            end
            if (en3) begin
                r_blk3[s]  <= r_blk2[s];
                r_prod[s]  <= ProdW'(r_blk2[s]) * ProdW'(r_small[s]);
                r_kprod[s] <= KprodW'(r_lo[s]) * KprodW'(Kern[s]);
                r_tail[s]  <= END_W'(r_small[s]) + (r_lt[s] ? END_W'(Kern[s]) : '0);
            end
            if (en4) begin
                r_blk4[s]  <= r_blk3[s];
                r_start[s] <= n_start[s];
                r_end[s]   <= n_end[s];
            end
        end
    end

    assign o_valid     = r_v4;
    assign o_block_row = r_blk4[SIDE_ROW];
    assign o_block_col = r_blk4[SIDE_COL];
    assign o_row_start = r_start[SIDE_ROW];
    assign o_row_end   = r_end[SIDE_ROW];
    assign o_col_start = r_start[SIDE_COL];
    assign o_col_end   = r_end[SIDE_COL];

    `TIBC_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, o_stall,
        r_v1 && r_v2 && r_v3 && r_v4, "input stalled with a bubble in the pipe")
    `TIBC_ASSERT_NEXT(a_last_advance, i_clk, i_rst_n, r_v3 && (!r_v4 || !i_stall),
        o_valid, "word lost before the output stage")
    `TIBC_ASSERT_SAME(a_row_order, i_clk, i_rst_n, o_valid,
        END_W'(o_row_start) <= o_row_end, "row end below row start")
    `TIBC_ASSERT_SAME(a_col_order, i_clk, i_rst_n, o_valid,
        END_W'(o_col_start) <= o_col_end, "column end below column start")

endmodule
